// File: rtl/esh_pkg.sv
package esh_pkg;

  localparam int TIMER_BITS_DEF       = 32;
  localparam int ERROR_COUNT_BITS_DEF = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_REV_LIMIT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_JUMP_LIMIT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_INTERVAL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_WINDOW   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_COLD       = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_HOT        = 3'd7;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_COLD   = 3'd1;
  localparam logic [2:0] ST_WARN   = 3'd2;
  localparam logic [2:0] ST_DANGER = 3'd3;
  localparam logic [2:0] ST_ERROR  = 3'd4;

  localparam logic signed [11:0] EOIL_COLD     = 12'sd960;
  localparam logic signed [11:0] EOIL_WARN     = 12'sd1760;
  localparam logic signed [11:0] EOIL_DANGER   = 12'sd2000;
  localparam logic signed [11:0] GOIL_COLD     = 12'sd640;
  localparam logic signed [11:0] GOIL_WARN     = 12'sd1600;
  localparam logic signed [11:0] GOIL_DANGER   = 12'sd1920;
  localparam logic signed [11:0] AFR_WARM_TEMP = 12'sd800;

  localparam logic [14:0] V_LOW_DANGER  = 15'd11500;
  localparam logic [14:0] V_LOW_WARN    = 15'd12000;
  localparam logic [14:0] V_HIGH_WARN   = 15'd14800;
  localparam logic [14:0] V_HIGH_DANGER = 15'd15500;
  localparam logic [14:0] V_RUN_RAISE   = 15'd1200;

  localparam logic [11:0] AFR_RICH_CRIT = 12'd1050;
  localparam logic [11:0] AFR_RICH_WARN = 12'd1150;
  localparam logic [11:0] AFR_LEAN_WARN = 12'd1550;
  localparam logic [11:0] AFR_LEAN_CRIT = 12'd1650;

  localparam logic [13:0] PRESS_RPM_CHECK   = 14'd4000;
  localparam logic [13:0] PRESS_MIN_AT_RPM  = 14'd2000;
  localparam logic [13:0] PRESS_NO_RPM_MBAR = 14'd1000;
  localparam logic [13:0] PRESS_NO_RPM_RPM  = 14'd100;

  typedef struct packed {
    logic signed [11:0] engine_oil_temp;
    logic               engine_oil_temp_fault;
    logic signed [11:0] gearbox_oil_temp;
    logic               gearbox_oil_temp_fault;
    logic [14:0]        supply_voltage_mv;
    logic               engine_running;
    logic [13:0]        engine_speed_rpm;
    logic [13:0]        oil_pressure_mbar;
    logic [11:0]        air_fuel_ratio;
    logic               probe_heating;
    logic [15:0]        elapsed_ms;
  } esh_in_t;

  typedef struct packed {
    logic [2:0] engine_oil_temp_status;
    logic [2:0] gearbox_oil_temp_status;
    logic [1:0] voltage_status;
    logic [2:0] rpm_status;
    logic [1:0] oil_pressure_status;
    logic [1:0] afr_status;
  } esh_out_t;

  typedef struct packed {
    logic [13:0] rev_limit_rpm;
    logic [13:0] rpm_jump_limit;
    logic [7:0]  rpm_error_limit;
    logic [15:0] rpm_check_interval_ms;
    logic [15:0] rpm_error_window_ms;
    logic [15:0] oil_press_hold_ms;
    logic [13:0] oil_press_min_cold_mbar;
    logic [13:0] oil_press_min_hot_mbar;
  } esh_cfg_t;

  localparam esh_cfg_t CFG_RESET = '{
    rev_limit_rpm:           14'd8000,
    rpm_jump_limit:          14'd2000,
    rpm_error_limit:         8'd3,
    rpm_check_interval_ms:   16'd100,
    rpm_error_window_ms:     16'd10000,
    oil_press_hold_ms:       16'd2000,
    oil_press_min_cold_mbar: 14'd1000,
    oil_press_min_hot_mbar:  14'd500
  };

  function automatic logic [2:0] grade_temp(input logic signed [11:0] t, input logic fault,
                                            input logic signed [11:0] cold,
                                            input logic signed [11:0] warn,
                                            input logic signed [11:0] danger);
    logic [2:0] st;
    if (fault) st = ST_ERROR;
    else if (t < cold) st = ST_COLD;
    else if (t < warn) st = ST_OK;
    else if (t < danger) st = ST_WARN;
    else st = ST_DANGER;
    return st;
  endfunction

  function automatic logic [2:0] grade_volt(input logic [14:0] v, input logic running);
    logic [14:0] raise;
    logic [2:0]  st;
    raise = running ? V_RUN_RAISE : 15'd0;
    if (v <= V_LOW_DANGER + raise) st = ST_DANGER;
    else if (v <= V_LOW_WARN + raise) st = ST_WARN;
    else if (v < V_HIGH_WARN) st = ST_OK;
    else if (v < V_HIGH_DANGER) st = ST_WARN;
    else st = ST_DANGER;
    return st;
  endfunction

  // Rich mixtures only matter once the oil is warm.
  function automatic logic [2:0] grade_afr(input logic [11:0] afr, input logic running,
                                           input logic heating, input logic warm);
    logic [2:0] st;
    if (!running || heating) st = ST_COLD;
    else if (afr <= AFR_RICH_CRIT) st = warm ? ST_DANGER : ST_OK;
    else if (afr <= AFR_RICH_WARN) st = warm ? ST_WARN : ST_OK;
    else if (afr < AFR_LEAN_WARN) st = ST_OK;
    else if (afr < AFR_LEAN_CRIT) st = ST_WARN;
    else st = ST_DANGER;
    return st;
  endfunction

endpackage

// File: rtl/esh_in_if.sv
interface esh_in_if import esh_pkg::*; ();
  logic    valid;
  logic    ready;
  esh_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/esh_out_if.sv
interface esh_out_if import esh_pkg::*; ();
  logic     valid;
  logic     ready;
  esh_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/esh_cfg_regs.sv
module esh_cfg_regs import esh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output esh_cfg_t               cfg
);

  esh_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REV_LIMIT:      cfg_r.rev_limit_rpm           <= cfg_wdata[13:0];
        REG_JUMP_LIMIT:     cfg_r.rpm_jump_limit          <= cfg_wdata[13:0];
        REG_ERROR_LIMIT:    cfg_r.rpm_error_limit         <= cfg_wdata[7:0];
        REG_CHECK_INTERVAL: cfg_r.rpm_check_interval_ms   <= cfg_wdata[15:0];
        REG_ERROR_WINDOW:   cfg_r.rpm_error_window_ms     <= cfg_wdata[15:0];
        REG_HOLD_TIME:      cfg_r.oil_press_hold_ms       <= cfg_wdata[15:0];
        REG_MIN_COLD:       cfg_r.oil_press_min_cold_mbar <= cfg_wdata[13:0];
        REG_MIN_HOT:        cfg_r.oil_press_min_hot_mbar  <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/esh_rpm_chk.sv
module esh_rpm_chk import esh_pkg::*; #(
  parameter int TIMER_BITS       = TIMER_BITS_DEF,
  parameter int ERROR_COUNT_BITS = ERROR_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [13:0] rpm,
  input  logic [13:0] press,
  input  logic [15:0] dt,
  input  esh_cfg_t    cfg,
  output logic [2:0]  status
);

  localparam int CNT_SUM_W = ERROR_COUNT_BITS + 2;
  localparam int CMP_W     = (ERROR_COUNT_BITS > 8) ? ERROR_COUNT_BITS : 8;
  localparam logic [CNT_SUM_W-1:0] COUNT_MAX = {2'b00, {ERROR_COUNT_BITS{1'b1}}};

  logic [13:0]                 prev_rpm_r, prev_rpm_nxt;
  logic [TIMER_BITS-1:0]       chk_t_r, chk_t_nxt;
  logic [TIMER_BITS-1:0]       win_t_r, win_t_nxt;
  logic [ERROR_COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                        err_r, err_nxt;

  logic [TIMER_BITS:0]         chk_sum, win_sum;
  logic [TIMER_BITS-1:0]       chk_inc, win_inc;
  logic                        chk_due, win_due;
  logic [13:0]                 diff;
  logic                        jump_err, press_err;
  logic [CNT_SUM_W-1:0]        cnt_sum;
  logic [ERROR_COUNT_BITS-1:0] cnt_a, cnt_b;
  logic                        over_limit;

  // Saturating timer increments.
  assign chk_sum = {1'b0, chk_t_r} + (TIMER_BITS+1)'(dt);
  assign win_sum = {1'b0, win_t_r} + (TIMER_BITS+1)'(dt);
  assign chk_inc = chk_sum[TIMER_BITS] ? '1 : chk_sum[TIMER_BITS-1:0];
  assign win_inc = win_sum[TIMER_BITS] ? '1 : win_sum[TIMER_BITS-1:0];

  assign chk_due = chk_t_r >= TIMER_BITS'(cfg.rpm_check_interval_ms);
  assign win_due = win_t_r >= TIMER_BITS'(cfg.rpm_error_window_ms);

  assign diff      = (rpm >= prev_rpm_r) ? rpm - prev_rpm_r : prev_rpm_r - rpm;
  assign jump_err  = chk_due && (diff >= cfg.rpm_jump_limit);
  assign press_err = chk_due && (press >= PRESS_NO_RPM_MBAR) && (rpm < PRESS_NO_RPM_RPM);

  assign cnt_sum = {2'b00, cnt_r} + CNT_SUM_W'(jump_err) + CNT_SUM_W'(press_err);
  assign cnt_a   = (cnt_sum > COUNT_MAX) ? '1 : cnt_sum[ERROR_COUNT_BITS-1:0];
  assign cnt_b   = win_due ? '0 : cnt_a;
  assign over_limit = CMP_W'(cnt_b) >= CMP_W'(cfg.rpm_error_limit);

  always_comb begin
    prev_rpm_nxt = prev_rpm_r;
    chk_t_nxt    = chk_t_r;
    win_t_nxt    = win_t_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    if (!err_r) begin
      prev_rpm_nxt = chk_due ? rpm : prev_rpm_r;
      chk_t_nxt    = chk_due ? '0 : chk_inc;
      win_t_nxt    = win_due ? '0 : win_inc;
      cnt_nxt      = cnt_b;
      if (over_limit) begin
        err_nxt   = 1'b1;
        win_t_nxt = '0;
        status    = ST_ERROR;
      end else begin
        status = (rpm >= cfg.rev_limit_rpm) ? ST_DANGER : ST_OK;
      end
    end else if (win_due) begin
      // The fault clears at the end of its window; this beat still reports danger.
      cnt_nxt   = '0;
      win_t_nxt = '0;
      err_nxt   = 1'b0;
      status    = ST_DANGER;
    end else begin
      win_t_nxt = win_inc;
      status    = ST_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_rpm_r <= '0;
      chk_t_r    <= '0;
      win_t_r    <= '0;
      cnt_r      <= '0;
      err_r      <= 1'b0;
    end else if (en) begin
      prev_rpm_r <= prev_rpm_nxt;
      chk_t_r    <= chk_t_nxt;
      win_t_r    <= win_t_nxt;
      cnt_r      <= cnt_nxt;
      err_r      <= err_nxt;
    end
  end

  a_check_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !err_r && chk_due) |=> (chk_t_r == '0))
    else $error("check timer not restarted after a plausibility check");

  a_fault_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !err_r && over_limit) |=> (err_r && win_t_r == '0))
    else $error("rpm fault not latched with a fresh window");

  a_fault_clears_on_window: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(err_r) && $past(rst_n)) |-> $past(en && win_due))
    else $error("rpm fault cleared before its window ended");

endmodule

// File: rtl/esh_oil_hold.sv
module esh_oil_hold import esh_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        running,
  input  logic        oil_cold,
  input  logic [13:0] rpm,
  input  logic [13:0] press,
  input  logic [15:0] dt,
  input  esh_cfg_t    cfg,
  output logic [2:0]  status
);

  logic                  hold_r, hold_nxt;
  logic [TIMER_BITS-1:0] hold_t_r, hold_t_nxt;
  logic                  danger_r, danger_nxt;
  logic [TIMER_BITS:0]   hold_sum;
  logic [13:0]           min_press;
  logic                  bad;

  assign hold_sum  = {1'b0, hold_t_r} + (TIMER_BITS+1)'(dt);
  assign min_press = oil_cold ? cfg.oil_press_min_cold_mbar : cfg.oil_press_min_hot_mbar;
  assign bad       = (press < min_press) ||
                     ((rpm >= PRESS_RPM_CHECK) && (press < PRESS_MIN_AT_RPM));

  // While holding, the last graded state stands. The engine being off clears that
  // state but leaves the hold and its timer untouched.
  always_comb begin
    hold_nxt   = hold_r;
    hold_t_nxt = hold_t_r;
    danger_nxt = danger_r;
    if (!running) begin
      danger_nxt = 1'b0;
    end else if (hold_r) begin
      if (hold_t_r >= TIMER_BITS'(cfg.oil_press_hold_ms)) begin
        hold_nxt   = 1'b0;
        hold_t_nxt = '0;
      end else begin
        hold_t_nxt = hold_sum[TIMER_BITS] ? '1 : hold_sum[TIMER_BITS-1:0];
      end
    end else begin
      danger_nxt = bad;
      hold_nxt   = bad;
    end
  end

  assign status = danger_nxt ? ST_DANGER : ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 1'b0;
      hold_t_r <= '0;
      danger_r <= 1'b0;
    end else if (en) begin
      hold_r   <= hold_nxt;
      hold_t_r <= hold_t_nxt;
      danger_r <= danger_nxt;
    end
  end

  a_hold_starts_in_danger: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(hold_r) && $past(rst_n)) |-> danger_r)
    else $error("oil pressure hold started without danger");

  a_idle_timer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_r |-> (hold_t_r == '0))
    else $error("oil hold timer running while no hold is active");

  a_hold_keeps_danger: assert property (@(posedge clk) disable iff (!rst_n)
    (en && hold_r && running) |=> ($stable(danger_r)))
    else $error("oil pressure state changed during a hold");

endmodule

// File: rtl/engine_sensor_health_monitor_core.sv
// A beat is held in the input register, then graded into the result register, which
// offers it on out_ch. Throughput: one beat per cycle while out_ch.ready does not stall
// the output; the rpm checker and oil hold state advance as each beat is graded.
// Reset (rst_n low, synchronous) restores the register defaults, clears all
// timers, counters and latched states, and empties both pipeline stages.
module engine_sensor_health_monitor_core import esh_pkg::*; #(
  parameter int TIMER_BITS       = TIMER_BITS_DEF,
  parameter int ERROR_COUNT_BITS = ERROR_COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  esh_in_if.sink                 in_ch,
  esh_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  esh_cfg_t cfg;
  esh_in_t  s1_data_r;
  logic     s1_v_r, s1_v_nxt;
  esh_out_t out_data_r, res;
  logic     out_v_r, out_v_nxt;
  logic     out_free, adv, in_acc;
  logic     oil_cold, oil_warm;
  logic [2:0] rpm_st, oil_st;

  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt  = in_acc || (s1_v_r && !adv);
    out_v_nxt = adv || (out_v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_ch.data;
    if (adv) out_data_r <= res;
  end

  esh_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A faulted engine oil sensor counts as very cold.
  assign oil_cold = s1_data_r.engine_oil_temp_fault || (s1_data_r.engine_oil_temp <= EOIL_COLD);
  assign oil_warm = !s1_data_r.engine_oil_temp_fault &&
                    (s1_data_r.engine_oil_temp >= AFR_WARM_TEMP);

  esh_rpm_chk #(
    .TIMER_BITS       (TIMER_BITS),
    .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
  ) u_rpm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .rpm    (s1_data_r.engine_speed_rpm),
    .press  (s1_data_r.oil_pressure_mbar),
    .dt     (s1_data_r.elapsed_ms),
    .cfg    (cfg),
    .status (rpm_st)
  );

  esh_oil_hold #(
    .TIMER_BITS (TIMER_BITS)
  ) u_oil (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .running  (s1_data_r.engine_running),
    .oil_cold (oil_cold),
    .rpm      (s1_data_r.engine_speed_rpm),
    .press    (s1_data_r.oil_pressure_mbar),
    .dt       (s1_data_r.elapsed_ms),
    .cfg      (cfg),
    .status   (oil_st)
  );

  logic [2:0] volt_st, afr_st;

  assign volt_st = grade_volt(s1_data_r.supply_voltage_mv, s1_data_r.engine_running);
  assign afr_st  = grade_afr(s1_data_r.air_fuel_ratio, s1_data_r.engine_running,
                             s1_data_r.probe_heating, oil_warm);

  always_comb begin
    res.engine_oil_temp_status  = grade_temp(s1_data_r.engine_oil_temp,
                                             s1_data_r.engine_oil_temp_fault,
                                             EOIL_COLD, EOIL_WARN, EOIL_DANGER);
    res.gearbox_oil_temp_status = grade_temp(s1_data_r.gearbox_oil_temp,
                                             s1_data_r.gearbox_oil_temp_fault,
                                             GOIL_COLD, GOIL_WARN, GOIL_DANGER);
    res.voltage_status          = volt_st[1:0];
    res.rpm_status              = rpm_st;
    res.oil_pressure_status     = oil_st[1:0];
    res.afr_status              = afr_st[1:0];
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

endmodule
